FILE: rtl/core/bcr_pkg.sv
`default_nettype none
package bcr_pkg;
   localparam int MAP_PAGES       = 65536;
   localparam int MAP_AW          = $clog2(MAP_PAGES);
   localparam int MAP_W           = 18;
   localparam int PHYS_W          = 17;
   localparam int MAX_CACHE_BANDS = 16;
   localparam int CB_W            = $clog2(MAX_CACHE_BANDS);
   localparam int MAX_ASSOC       = 64;
   localparam int MAX_SEGMENTS    = 32;
   localparam int BP_W            = 17;
   localparam int CBC_W           = 5;
   localparam int DBC_W           = 11;
   localparam int USABLE_W        = BP_W + DBC_W;
   localparam int CNT_W           = 6;
   localparam int SEG_W           = 5;
   localparam int DIV_W           = 16;

   localparam logic [1:0] REG_BAND_PAGES       = 2'd0;
   localparam logic [1:0] REG_CACHE_BAND_COUNT = 2'd1;
   localparam logic [1:0] REG_DATA_BAND_COUNT  = 2'd2;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [BP_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_W-1:0]  quotient;
      logic [BP_W-1:0]   remainder;
   } div_rsp_type;
endpackage
`default_nettype wire

FILE: rtl/core/band_cache_request_remapper.sv
`default_nettype none
// Band cache request remapper. A read request walks its pages through the page map,
// one page per cycle while no run boundary waits for the response slot, and returns
// one word per physically contiguous run; a write request is cut at data band
// boundaries and each part that fits is appended at the write pointer of cache band
// (data band mod cache bands), one map entry written per cycle, while a part that
// does not fit returns a needs_gc word and maps nothing. Write setup is mostly the two
// serial divisions. A word that waits for rsp_ready holds the walk until it is taken.
// Out-of-range requests return a single reject word. After reset the page map is
// swept to unmapped, one entry per cycle; req_ready stays low until the sweep ends,
// while CSR writes are taken at any time.
module band_cache_request_remapper (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_command,
   input  wire  [15:0] req_start_page,
   input  wire  [5:0]  req_page_count,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [16:0] rsp_phys_page,
   output logic [4:0]  rsp_first_segment,
   output logic [5:0]  rsp_segment_count,
   output logic        rsp_needs_gc,
   output logic        rsp_reject,
   output logic        rsp_last,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [16:0] csr_wdata
);
   localparam int PW  = bcr_pkg::PHYS_W;
   localparam int AW  = bcr_pkg::MAP_AW;
   localparam int NW  = bcr_pkg::CNT_W;
   localparam int SW  = bcr_pkg::SEG_W;
   localparam int BW  = bcr_pkg::BP_W;
   localparam int UW  = bcr_pkg::USABLE_W;
   localparam int CBW = bcr_pkg::CB_W;
   localparam int PSW = bcr_pkg::DIV_W;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_CHECK    = 4'd1;
   localparam logic [3:0] ST_REJECT   = 4'd2;
   localparam logic [3:0] ST_RD_DATA  = 4'd3;
   localparam logic [3:0] ST_RD_FINAL = 4'd4;
   localparam logic [3:0] ST_DIV_BAND = 4'd5;
   localparam logic [3:0] ST_DIV_CB   = 4'd6;
   localparam logic [3:0] ST_WR_BASE  = 4'd7;
   localparam logic [3:0] ST_WR_CALC  = 4'd8;
   localparam logic [3:0] ST_WR_EMIT  = 4'd9;
   localparam logic [3:0] ST_WR_MAP   = 4'd10;
   localparam logic [3:0] ST_WR_NEXT  = 4'd11;

   // configuration
   logic [BW-1:0]               band_pages_ff;
   logic [bcr_pkg::CBC_W-1:0]   cache_band_count_ff;
   logic [bcr_pkg::DBC_W-1:0]   data_band_count_ff;
   logic [BW-1:0]               bp_eff;
   logic [bcr_pkg::CBC_W-1:0]   cbc_eff;
   logic [UW-1:0]               usable_ff;

   // control
   logic [3:0]     state_ff, state_in;
   logic [AW:0]    clear_ff, clear_in;
   logic           clearing;

   // request
   logic           cmd_ff, cmd_in;
   logic [AW-1:0]  start_ff, start_in;
   logic [NW-1:0]  cnt_ff, cnt_in;
   logic [NW-1:0]  j_ff, j_in;
   logic [NW-1:0]  first_ff, first_in;
   logic [PW-1:0]  phys_ff, phys_in;
   logic [PW-1:0]  prev_ff, prev_in;

   // write part
   logic [BW-1:0]  off_ff, off_in;
   logic [CBW-1:0] cbi_ff, cbi_in;
   logic [PSW-1:0] pos_ff, pos_in;
   logic [PW-1:0]  begin_ff, begin_in;
   logic [NW-1:0]  len_ff, len_in;
   logic           fit_ff, fit_in;
   logic [PW-1:0]  used_ff, used_in;
   logic [NW-1:0]  k_ff, k_in;
   logic [PW-1:0]  wp_ff [bcr_pkg::MAX_CACHE_BANDS];
   logic [bcr_pkg::MAX_ASSOC-1:0] occ_ff [bcr_pkg::MAX_CACHE_BANDS];
   logic           wp_we;

   // result word
   logic           rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]  rsp_phys_ff, rsp_phys_in;
   logic [SW-1:0]  rsp_first_ff, rsp_first_in;
   logic [NW-1:0]  rsp_count_ff, rsp_count_in;
   logic           rsp_gc_ff, rsp_gc_in;
   logic           rsp_rej_ff, rsp_rej_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           slot_free;
   logic           emit;

   // page map port
   logic                 map_we, map_re;
   logic [AW-1:0]        map_waddr, map_raddr;
   logic [bcr_pkg::MAP_W-1:0] map_wdata, map_rdata;

   bcr_pkg::div_req_type div_req;
   bcr_pkg::div_rsp_type div_rsp;

   // scratch
   logic [PW-1:0]  end_page;
   logic           bad;
   logic [PW-1:0]  cur;
   logic           discont;
   logic [BW-1:0]  left;
   logic [NW-1:0]  remain;
   logic [NW-1:0]  len_c;
   logic [PW-1:0]  used_c;
   logic [BW-1:0]  avail;
   logic [NW-1:0]  j_next;

   bcr_ram #(.WIDTH(bcr_pkg::MAP_W), .DEPTH(bcr_pkg::MAP_PAGES)) u_page_map (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .re    (map_re),
      .raddr (map_raddr),
      .rdata (map_rdata)
   );

   bcr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // saturate the band geometry
   always_comb begin
      bp_eff = (band_pages_ff == '0) ? BW'(1) : band_pages_ff;
      if (cache_band_count_ff == '0) begin
         cbc_eff = bcr_pkg::CBC_W'(1);
      end else if (cache_band_count_ff > bcr_pkg::CBC_W'(bcr_pkg::MAX_CACHE_BANDS)) begin
         cbc_eff = bcr_pkg::CBC_W'(bcr_pkg::MAX_CACHE_BANDS);
      end else begin
         cbc_eff = cache_band_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_pages_ff       <= BW'(1024);
         cache_band_count_ff <= bcr_pkg::CBC_W'(1);
         data_band_count_ff  <= bcr_pkg::DBC_W'(63);
      end else if (csr_we) begin
         case (csr_index)
            bcr_pkg::REG_BAND_PAGES:       band_pages_ff <= csr_wdata;
            bcr_pkg::REG_CACHE_BAND_COUNT:
               cache_band_count_ff <= csr_wdata[bcr_pkg::CBC_W-1:0];
            bcr_pkg::REG_DATA_BAND_COUNT:
               data_band_count_ff <= csr_wdata[bcr_pkg::DBC_W-1:0];
            default: ;
         endcase
      end
      usable_ff <= UW'(data_band_count_ff) * UW'(bp_eff);
   end

   assign clearing  = !clear_ff[AW];
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !clearing;

   always_comb begin
      state_in  = state_ff;
      clear_in  = clearing ? clear_ff + (AW+1)'(1) : clear_ff;
      cmd_in    = cmd_ff;
      start_in  = start_ff;
      cnt_in    = cnt_ff;
      j_in      = j_ff;
      first_in  = first_ff;
      phys_in   = phys_ff;
      prev_in   = prev_ff;
      off_in    = off_ff;
      cbi_in    = cbi_ff;
      pos_in    = pos_ff;
      begin_in  = begin_ff;
      len_in    = len_ff;
      fit_in    = fit_ff;
      used_in   = used_ff;
      k_in      = k_ff;
      wp_we     = 1'b0;

      emit         = 1'b0;
      rsp_phys_in  = rsp_phys_ff;
      rsp_first_in = rsp_first_ff;
      rsp_count_in = rsp_count_ff;
      rsp_gc_in    = rsp_gc_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_last_in  = rsp_last_ff;

      map_we    = clearing;
      map_waddr = clear_ff[AW-1:0];
      map_wdata = '0;
      map_re    = 1'b0;
      map_raddr = start_ff;

      div_req.start    = 1'b0;
      div_req.dividend = start_ff;
      div_req.divisor  = bp_eff;

      end_page = {1'b0, start_ff} + PW'(cnt_ff);
      bad = (cnt_ff == '0) || (cnt_ff > NW'(bcr_pkg::MAX_SEGMENTS))
         || (UW'(end_page) > usable_ff) || (end_page > PW'(bcr_pkg::MAP_PAGES));

      // unmapped pages map to themselves
      cur = map_rdata[PW] ? map_rdata[PW-1:0]
                          : {1'b0, AW'(start_ff + AW'(j_ff))};
      discont = (j_ff != '0) && (PW'(prev_ff + PW'(1)) != cur);

      left   = bp_eff - off_ff;
      remain = cnt_ff - j_ff;
      len_c  = (BW'(remain) < left) ? remain : left[NW-1:0];
      used_c = wp_ff[cbi_ff];
      avail  = (used_c < bp_eff) ? BW'(bp_eff - used_c) : '0;
      j_next = j_ff + len_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd_in   = req_command;
               start_in = req_start_page;
               cnt_in   = req_page_count;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            j_in     = '0;
            first_in = '0;
            if (bad) begin
               state_in = ST_REJECT;
            end else if (!cmd_ff) begin
               map_re    = 1'b1;
               map_raddr = start_ff;
               state_in  = ST_RD_DATA;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV_BAND;
            end
         end
         ST_REJECT: begin
            if (slot_free) begin
               emit         = 1'b1;
               rsp_phys_in  = '0;
               rsp_first_in = '0;
               rsp_count_in = '0;
               rsp_gc_in    = 1'b0;
               rsp_rej_in   = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_RD_DATA: begin
            // hold the map output while a run boundary waits for the slot
            if (!(discont && !slot_free)) begin
               if (discont) begin
                  emit         = 1'b1;
                  rsp_phys_in  = phys_ff;
                  rsp_first_in = first_ff[SW-1:0];
                  rsp_count_in = j_ff - first_ff;
                  rsp_gc_in    = 1'b0;
                  rsp_rej_in   = 1'b0;
                  rsp_last_in  = 1'b0;
               end
               if (discont || (j_ff == '0)) begin
                  first_in = j_ff;
                  phys_in  = cur;
               end
               prev_in = cur;
               if (j_ff == cnt_ff - NW'(1)) begin
                  state_in = ST_RD_FINAL;
               end else begin
                  j_in      = j_ff + NW'(1);
                  map_re    = 1'b1;
                  map_raddr = AW'(start_ff + AW'(j_ff) + AW'(1));
               end
            end
         end
         ST_RD_FINAL: begin
            if (slot_free) begin
               emit         = 1'b1;
               rsp_phys_in  = phys_ff;
               rsp_first_in = first_ff[SW-1:0];
               rsp_count_in = cnt_ff - first_ff;
               rsp_gc_in    = 1'b0;
               rsp_rej_in   = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DIV_BAND: begin
            // data band and offset, then split the band over the cache bands
            if (div_rsp.done) begin
               off_in           = div_rsp.remainder;
               div_req.start    = 1'b1;
               div_req.dividend = div_rsp.quotient;
               div_req.divisor  = BW'(cbc_eff);
               state_in         = ST_DIV_CB;
            end
         end
         ST_DIV_CB: begin
            div_req.divisor = BW'(cbc_eff);
            if (div_rsp.done) begin
               pos_in   = div_rsp.quotient;
               cbi_in   = div_rsp.remainder[CBW-1:0];
               state_in = ST_WR_BASE;
            end
         end
         ST_WR_BASE: begin
            begin_in = PW'(usable_ff[PW-1:0] + PW'(PW'(cbi_ff) * bp_eff));
            state_in = ST_WR_CALC;
         end
         ST_WR_CALC: begin
            len_in   = len_c;
            fit_in   = BW'(len_c) <= avail;
            used_in  = used_c;
            phys_in  = (BW'(len_c) <= avail) ? PW'(begin_ff + used_c) : begin_ff;
            state_in = ST_WR_EMIT;
         end
         ST_WR_EMIT: begin
            if (slot_free) begin
               emit         = 1'b1;
               rsp_phys_in  = phys_ff;
               rsp_first_in = j_ff[SW-1:0];
               rsp_count_in = len_ff;
               rsp_gc_in    = !fit_ff;
               rsp_rej_in   = 1'b0;
               rsp_last_in  = (j_next == cnt_ff);
               k_in         = '0;
               state_in     = fit_ff ? ST_WR_MAP : ST_WR_NEXT;
            end
         end
         ST_WR_MAP: begin
            map_we    = 1'b1;
            map_waddr = AW'(start_ff + AW'(j_ff) + AW'(k_ff));
            map_wdata = {1'b1, PW'(phys_ff + PW'(k_ff))};
            k_in      = k_ff + NW'(1);
            if (k_ff == len_ff - NW'(1)) begin
               wp_we    = 1'b1;
               state_in = ST_WR_NEXT;
            end
         end
         ST_WR_NEXT: begin
            j_in   = j_next;
            off_in = '0;
            if (j_next == cnt_ff) begin
               state_in = ST_IDLE;
            end else begin
               // advance to the next data band
               if (bcr_pkg::CBC_W'(cbi_ff) == cbc_eff - bcr_pkg::CBC_W'(1)) begin
                  cbi_in   = '0;
                  pos_in   = pos_ff + PSW'(1);
                  begin_in = usable_ff[PW-1:0];
               end else begin
                  cbi_in   = cbi_ff + CBW'(1);
                  begin_in = PW'(begin_ff + bp_eff);
               end
               state_in = ST_WR_CALC;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < bcr_pkg::MAX_CACHE_BANDS; i++) begin
            wp_ff[i]  <= '0;
            occ_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wp_we) begin
            wp_ff[cbi_ff] <= PW'(used_ff + PW'(len_ff));
            if (pos_ff < PSW'(bcr_pkg::MAX_ASSOC)) begin
               occ_ff[cbi_ff][pos_ff[$clog2(bcr_pkg::MAX_ASSOC)-1:0]] <= 1'b1;
            end
         end
      end
      cmd_ff       <= cmd_in;
      start_ff     <= start_in;
      cnt_ff       <= cnt_in;
      j_ff         <= j_in;
      first_ff     <= first_in;
      phys_ff      <= phys_in;
      prev_ff      <= prev_in;
      off_ff       <= off_in;
      cbi_ff       <= cbi_in;
      pos_ff       <= pos_in;
      begin_ff     <= begin_in;
      len_ff       <= len_in;
      fit_ff       <= fit_in;
      used_ff      <= used_in;
      k_ff         <= k_in;
      rsp_phys_ff  <= rsp_phys_in;
      rsp_first_ff <= rsp_first_in;
      rsp_count_ff <= rsp_count_in;
      rsp_gc_ff    <= rsp_gc_in;
      rsp_rej_ff   <= rsp_rej_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_phys_page     = rsp_phys_ff;
   assign rsp_first_segment = rsp_first_ff;
   assign rsp_segment_count = rsp_count_ff;
   assign rsp_needs_gc      = rsp_gc_ff;
   assign rsp_reject        = rsp_rej_ff;
   assign rsp_last          = rsp_last_ff;
endmodule
`default_nettype wire

FILE: rtl/core/bcr_ram.sv
`default_nettype none
module bcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire [$clog2(DEPTH)-1:0]  waddr,
   input  wire [WIDTH-1:0]          wdata,
   input  wire                      re,
   input  wire [$clog2(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/bcr_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module bcr_div (
   input  wire                  clock,
   input  wire                  reset,
   input  bcr_pkg::div_req_type req,
   output bcr_pkg::div_rsp_type rsp
);
   localparam int CW = $clog2(bcr_pkg::DIV_W + 1);

   logic [CW-1:0]                count_ff, count_in;
   logic                         done_ff, done_in;
   logic [bcr_pkg::DIV_W-1:0]    dvd_ff, dvd_in;
   logic [bcr_pkg::BP_W-1:0]     rem_ff, rem_in;
   logic [bcr_pkg::BP_W-1:0]     div_ff, div_in;
   logic [bcr_pkg::BP_W:0]       rem_sh;
   logic                         ge;

   always_comb begin
      rem_sh   = {rem_ff, dvd_ff[bcr_pkg::DIV_W-1]};
      ge       = rem_sh >= {1'b0, div_ff};
      count_in = count_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      done_in  = (count_ff == CW'(1));
      if (req.start) begin
         count_in = CW'(bcr_pkg::DIV_W);
         dvd_in   = req.dividend;
         rem_in   = '0;
         div_in   = req.divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - CW'(1);
         dvd_in   = {dvd_ff[bcr_pkg::DIV_W-2:0], ge};
         rem_in   = ge ? bcr_pkg::BP_W'(rem_sh - {1'b0, div_ff})
                       : rem_sh[bcr_pkg::BP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = dvd_ff;
   assign rsp.remainder = rem_ff;
endmodule
`default_nettype wire

FILE: test/band_cache_request_remapper_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module band_cache_request_remapper_tb;
   // index past the last register; writes to it must be ignored
   localparam logic [1:0] REG_UNUSED   = 2'd3;
   localparam logic       CMD_READ     = 1'b0;
   localparam logic       CMD_WRITE    = 1'b1;
   localparam int         STALL_LIMIT  = 200000;
   localparam int         DRAIN_CYCLES = 200;

   typedef struct packed {
      logic                       command;
      logic [15:0]                start_page;
      logic [bcr_pkg::CNT_W-1:0]  page_count;
   } request_type;

   typedef struct packed {
      logic [bcr_pkg::PHYS_W-1:0] phys_page;
      logic [bcr_pkg::SEG_W-1:0]  first_segment;
      logic [bcr_pkg::CNT_W-1:0]  segment_count;
      logic                       needs_gc;
      logic                       reject;
      logic                       last;
   } chunk_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_command = 1'b0;
   logic [15:0]       req_start_page = '0;
   logic [5:0]        req_page_count = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [16:0]       rsp_phys_page;
   logic [4:0]        rsp_first_segment;
   logic [5:0]        rsp_segment_count;
   logic              rsp_needs_gc;
   logic              rsp_reject;
   logic              rsp_last;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [16:0]       csr_wdata = '0;

   band_cache_request_remapper dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_start_page(req_start_page), .req_page_count(req_page_count),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_phys_page(rsp_phys_page),
      .rsp_first_segment(rsp_first_segment), .rsp_segment_count(rsp_segment_count),
      .rsp_needs_gc(rsp_needs_gc), .rsp_reject(rsp_reject), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow copy of the remapper: registers, page map, pointers, occupancy
   logic [bcr_pkg::BP_W-1:0]   sh_band_pages;
   logic [bcr_pkg::CBC_W-1:0]  sh_cache_bands;
   logic [bcr_pkg::DBC_W-1:0]  sh_data_bands;
   logic [bcr_pkg::MAP_W-1:0]  sh_page_map [bcr_pkg::MAP_PAGES];
   logic [bcr_pkg::PHYS_W-1:0] sh_write_ptr [bcr_pkg::MAX_CACHE_BANDS];
   logic [63:0]                sh_occupancy [bcr_pkg::MAX_CACHE_BANDS];

   request_type pending_requests [$];
   chunk_type   expected_chunks [$];

   int  error_count = 0;
   int  requests_taken = 0;
   int  words_checked = 0;
   int  gc_words = 0;
   int  reject_words = 0;
   int  idle_cycles = 0;
   bit  req_taken = 0;
   bit  no_idle = 0;
   bit  did_long_hold = 0;
   int  send_gap = 0;
   int  recv_gap = 0;

   initial forever #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic longint eff_band_pages();
      return (sh_band_pages == 0) ? 1 : longint'(sh_band_pages);
   endfunction

   function automatic longint usable_pages();
      return longint'(sh_data_bands) * eff_band_pages();
   endfunction

   function automatic logic [bcr_pkg::PHYS_W-1:0] map_lookup(longint page);
      logic [bcr_pkg::MAP_W-1:0] e;
      e = sh_page_map[page % bcr_pkg::MAP_PAGES];
      return e[bcr_pkg::MAP_W-1] ? e[bcr_pkg::PHYS_W-1:0] : bcr_pkg::PHYS_W'(page);
   endfunction

   // work out the chunks one request yields and update the shadow state
   task automatic remap_request(request_type rq);
      longint bp, usable, start, cnt, j, first, page, db, left, len, used, avail;
      longint begin_pg, phys, pos;
      int cbc, cbi;
      logic [bcr_pkg::PHYS_W-1:0] prev, cur, run_phys;
      chunk_type c;
      bp = eff_band_pages();
      usable = usable_pages();
      start = rq.start_page;
      cnt = rq.page_count;
      cbc = (sh_cache_bands == 0) ? 1 :
            (sh_cache_bands > bcr_pkg::MAX_CACHE_BANDS) ? bcr_pkg::MAX_CACHE_BANDS
                                                        : sh_cache_bands;
      if (cnt == 0 || cnt > bcr_pkg::MAX_SEGMENTS || start + cnt > usable ||
          start + cnt > bcr_pkg::MAP_PAGES) begin
         c = '0;
         c.reject = 1'b1;
         c.last = 1'b1;
         expected_chunks.push_back(c);
         return;
      end
      if (rq.command == CMD_READ) begin
         prev = map_lookup(start);
         run_phys = prev;
         first = 0;
         for (j = 1; j < cnt; j++) begin
            cur = map_lookup(start + j);
            if (bcr_pkg::PHYS_W'(prev + 1) != cur) begin
               c = '0;
               c.phys_page = run_phys;
               c.first_segment = bcr_pkg::SEG_W'(first);
               c.segment_count = bcr_pkg::CNT_W'(j - first);
               expected_chunks.push_back(c);
               first = j;
               run_phys = cur;
            end
            prev = cur;
         end
         c = '0;
         c.phys_page = run_phys;
         c.first_segment = bcr_pkg::SEG_W'(first);
         c.segment_count = bcr_pkg::CNT_W'(cnt - first);
         c.last = 1'b1;
         expected_chunks.push_back(c);
         return;
      end
      j = 0;
      while (j < cnt) begin
         page = start + j;
         db = page / bp;
         left = bp - page % bp;
         len = (cnt - j < left) ? cnt - j : left;
         cbi = int'(db % cbc);
         begin_pg = usable + longint'(cbi) * bp;
         used = sh_write_ptr[cbi];
         avail = (used < bp) ? bp - used : 0;
         c = '0;
         if (len > avail) begin
            c.needs_gc = 1'b1;
            phys = begin_pg;
         end else begin
            phys = begin_pg + used;
            pos = db / cbc;
            for (longint k = 0; k < len; k++)
               sh_page_map[(page + k) % bcr_pkg::MAP_PAGES] =
                  {1'b1, bcr_pkg::PHYS_W'(phys + k)};
            sh_write_ptr[cbi] = bcr_pkg::PHYS_W'(used + len);
            if (pos < bcr_pkg::MAX_ASSOC) sh_occupancy[cbi][pos] = 1'b1;
         end
         c.phys_page = bcr_pkg::PHYS_W'(phys);
         c.first_segment = bcr_pkg::SEG_W'(j);
         c.segment_count = bcr_pkg::CNT_W'(len);
         c.last = (j + len == cnt);
         expected_chunks.push_back(c);
         j += len;
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // driver: hold a word until taken, then advance after a random gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            request_type rq;
            rq = pending_requests.pop_front();
            req_command <= rq.command;
            req_start_page <= rq.start_page;
            req_page_count <= rq.page_count;
            req_valid <= 1'b1;
            send_gap = no_idle ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random back-pressure, plus one long hold-off once traffic is flowing
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!did_long_hold && requests_taken >= 150) begin
            did_long_hold = 1;
            recv_gap = 500;
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!no_idle) recv_gap = pick_gap();
         end
      end
   end

   // monitor: predict on request accept, check on response accept
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (req_valid && req_ready) begin
            request_type rq;
            rq.command = req_command;
            rq.start_page = req_start_page;
            rq.page_count = req_page_count;
            remap_request(rq);
            requests_taken++;
            req_taken = 1;
            idle_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            words_checked++;
            if (expected_chunks.size() == 0) begin
               report_mismatch("unexpected response word", 1, 0);
            end else begin
               chunk_type w;
               w = expected_chunks.pop_front();
               if (rsp_phys_page != w.phys_page)
                  report_mismatch("phys_page", rsp_phys_page, w.phys_page);
               if (rsp_first_segment != w.first_segment)
                  report_mismatch("first_segment", rsp_first_segment, w.first_segment);
               if (rsp_segment_count != w.segment_count)
                  report_mismatch("segment_count", rsp_segment_count, w.segment_count);
               if (rsp_needs_gc != w.needs_gc)
                  report_mismatch("needs_gc", rsp_needs_gc, w.needs_gc);
               if (rsp_reject != w.reject)
                  report_mismatch("reject", rsp_reject, w.reject);
               if (rsp_last != w.last)
                  report_mismatch("last", rsp_last, w.last);
               gc_words += w.needs_gc;
               reject_words += w.reject;
            end
         end
         // the post-reset map sweep is well under this limit
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d words outstanding", expected_chunks.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [16:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         bcr_pkg::REG_BAND_PAGES:       sh_band_pages = value;
         bcr_pkg::REG_CACHE_BAND_COUNT: sh_cache_bands = value[bcr_pkg::CBC_W-1:0];
         bcr_pkg::REG_DATA_BAND_COUNT:  sh_data_bands = value[bcr_pkg::DBC_W-1:0];
         default: ;
      endcase
   endtask

   task automatic queue_request(logic cmd, int start, int cnt);
      request_type rq;
      rq.command = cmd;
      rq.start_page = 16'(start);
      rq.page_count = bcr_pkg::CNT_W'(cnt);
      pending_requests.push_back(rq);
   endtask

   // mostly in-range requests, some near the origin to reuse mapped pages, some noise
   task automatic queue_random(int n);
      longint lim;
      int cnt, start, r;
      lim = usable_pages();
      if (lim > bcr_pkg::MAP_PAGES) lim = bcr_pkg::MAP_PAGES;
      repeat (n) begin
         r = $urandom_range(99);
         cnt = $urandom_range(bcr_pkg::MAX_SEGMENTS, 1);
         if (r < 12 || lim < cnt) begin
            cnt = $urandom_range(63);
            start = $urandom_range(65535);
         end else if (r < 55) begin
            start = $urandom_range((lim - cnt < 300) ? int'(lim - cnt) : 300);
         end else begin
            start = $urandom_range(int'(lim - cnt));
         end
         queue_request(1'($urandom_range(1)), start, cnt);
      end
   endtask

   // wait until every request is sent and every word is back, then let the block settle
   task automatic drain();
      while (pending_requests.size() != 0 || req_valid || expected_chunks.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      sh_band_pages = 1024;
      sh_cache_bands = 1;
      sh_data_bands = 63;
      for (int i = 0; i < bcr_pkg::MAP_PAGES; i++) sh_page_map[i] = '0;
      for (int i = 0; i < bcr_pkg::MAX_CACHE_BANDS; i++) begin
         sh_write_ptr[i] = '0;
         sh_occupancy[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, usable region ends at page 64512
      queue_request(CMD_READ, 0, 1);          // unmapped page maps to itself
      queue_request(CMD_WRITE, 0, 32);
      queue_request(CMD_READ, 0, 32);         // fully mapped, one run
      queue_request(CMD_WRITE, 1020, 8);      // split at a band boundary
      queue_request(CMD_READ, 1016, 16);      // mixed mapped and unmapped runs
      queue_request(CMD_WRITE, 10, 4);        // remap inside a mapped run
      queue_request(CMD_READ, 0, 32);
      queue_request(CMD_READ, 5, 0);          // zero count
      queue_request(CMD_WRITE, 5, 33);        // count above the limit
      queue_request(CMD_READ, 5, 63);
      queue_request(CMD_WRITE, 65535, 1);     // beyond usable pages
      queue_request(CMD_READ, 64511, 1);      // last usable page
      queue_request(CMD_WRITE, 64481, 32);    // ends one page past the usable limit
      queue_request(CMD_READ, 64512, 1);
      queue_request(CMD_READ, 64481, 32);
      queue_random(100);
      drain();

      // tiny bands: frequent splits and cache bands that run out of room
      csr_write(bcr_pkg::REG_BAND_PAGES, 17'd8);
      csr_write(bcr_pkg::REG_CACHE_BAND_COUNT, 17'd4);
      csr_write(bcr_pkg::REG_DATA_BAND_COUNT, 17'd16);
      no_idle = 1;
      queue_random(60);
      drain();
      no_idle = 0;
      queue_random(60);
      drain();

      // wide settings: usable region capped by the map size
      csr_write(bcr_pkg::REG_BAND_PAGES, 17'd65536);
      csr_write(bcr_pkg::REG_CACHE_BAND_COUNT, 17'd16);
      csr_write(bcr_pkg::REG_DATA_BAND_COUNT, 17'd1024);
      queue_request(CMD_WRITE, 65504, 32);
      queue_request(CMD_READ, 65504, 32);
      queue_request(CMD_READ, 65535, 1);
      queue_random(120);
      drain();

      // narrowest settings; the write to the unused index changes nothing
      csr_write(bcr_pkg::REG_BAND_PAGES, 17'd1);
      csr_write(bcr_pkg::REG_CACHE_BAND_COUNT, 17'd1);
      csr_write(bcr_pkg::REG_DATA_BAND_COUNT, 17'd1);
      csr_write(REG_UNUSED, 17'h1FFFF);
      queue_request(CMD_WRITE, 0, 1);
      queue_request(CMD_WRITE, 0, 1);         // band full
      queue_request(CMD_READ, 0, 2);
      queue_random(30);
      drain();

      $display("Run covered %0d requests and %0d response words", requests_taken,
               words_checked);
      $display("  including %0d needs_gc and %0d reject words across four settings",
               gc_words, reject_words);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
